[rtl/stcbt_pkg.sv]
// Shared types and constants for the second-tick calendar and burst timer.
// Used by stcbt_calendar, stcbt_slots and the top level; depends on nothing.
package stcbt_pkg;

    localparam int SLOT_MAX       = 3;
    localparam int PERIOD_W       = 22;
    localparam int TIME_W         = 32;
    localparam int CFG_IDX_W      = 2;

    localparam logic [TIME_W-1:0]   DAY_UNITS   = 32'hA4CB_8000;
    localparam logic [TIME_W-1:0]   TICK_UNITS  = 32'd32000;
    localparam logic [PERIOD_W-1:0] TICK_MS     = 22'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 22'd1000;

    localparam logic [4:0] DAY_RST   = 5'd1;
    localparam logic [3:0] MONTH_RST = 4'd1;
    localparam logic [7:0] YEAR_RST  = 8'd125;

    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_PERIOD0 = 2'd1,
        CFG_PERIOD1 = 2'd2,
        CFG_PERIOD2 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t               operation;
        logic [4:0]        load_day;
        logic [3:0]        load_month;
        logic [7:0]        load_year;
        logic [TIME_W-1:0] load_time;
    } in_word_t;

    typedef struct packed {
        logic [4:0]          day_of_month;
        logic [3:0]          month_of_year;
        logic [7:0]          year_since_1900;
        logic [TIME_W-1:0]   time_of_day;
        logic [SLOT_MAX-1:0] burst_fire_mask;
    } out_word_t;

    // Current calendar state handed from the calendar to the top level
    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [7:0]        year;
        logic [TIME_W-1:0] tod;
    } cal_state_t;

    // Configuration write handed to the slot bank
    typedef struct packed {
        logic                en;
        cfg_idx_t            idx;
        logic [PERIOD_W-1:0] data;
    } cfg_wr_t;

    // Register index of the period of slot i
    function automatic cfg_idx_t period_index(input int i);
        logic [CFG_IDX_W-1:0] raw;
        raw = CFG_IDX_W'(i + 1);
        return cfg_idx_t'(raw);
    endfunction

endpackage

[rtl/second_tick_calendar_and_burst_timer.sv]
// Top level: handshakes, result word assembly, calendar and burst slot bank.
// Depends on stcbt_pkg, stcbt_calendar and stcbt_slots.
// The result word becomes valid in the cycle after the input word is accepted.
// Throughput: one word per cycle; a word is taken whenever the result slot is
// empty or its word leaves in the same cycle. Configuration writes are never stalled.
// Reset: time 0, date 1/1 of year 125, all periods and countdowns 1000, no slot enabled.
module second_tick_calendar_and_burst_timer
#(
    parameter int BURST_SLOTS = stcbt_pkg::SLOT_MAX
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  stcbt_pkg::in_word_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output stcbt_pkg::out_word_t                 out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  stcbt_pkg::cfg_idx_t                  cfg_index,
    input  logic [stcbt_pkg::PERIOD_W-1:0]       cfg_data
);
    import stcbt_pkg::*;

    logic                out_valid_reg, out_valid_next;
    logic                accept;
    cal_state_t          cal;
    cfg_wr_t             cfg;
    logic [SLOT_MAX-1:0] fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cfg_ready = 1'b1;
    assign cfg.en    = cfg_valid;
    assign cfg.idx   = cfg_index;
    assign cfg.data  = cfg_data;

    stcbt_calendar u_calendar
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .word    (in_data),
        .state   (cal)
    );

    stcbt_slots
    #(
        .BURST_SLOTS (BURST_SLOTS)
    )
    u_slots
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .operation (in_data.operation),
        .cfg       (cfg),
        .fire      (fire)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // State registers only move on acceptance, so they hold the pending result
    assign out_valid                = out_valid_reg;
    assign out_data.day_of_month    = cal.day;
    assign out_data.month_of_year   = cal.month;
    assign out_data.year_since_1900 = cal.year;
    assign out_data.time_of_day     = cal.tod;
    assign out_data.burst_fire_mask = fire;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

[rtl/stcbt_calendar.sv]
// Time of day and date registers with their tick and load update logic.
// Depends on stcbt_pkg.
module stcbt_calendar
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  stcbt_pkg::in_word_t   word,
    output stcbt_pkg::cal_state_t state
);
    import stcbt_pkg::*;

    localparam logic [4:0] MONTHS = 5'd12;

    logic [TIME_W-1:0] tod_reg,   tod_next;
    logic [4:0]        day_reg,   day_next;
    logic [3:0]        month_reg, month_next;
    logic [7:0]        year_reg,  year_next;

    logic [TIME_W:0]   tod_sum;
    logic              day_wrap;
    logic [5:0]        day_inc;
    logic [5:0]        month_len;
    logic [4:0]        month_inc;

    always_comb
    begin
        unique case (month_reg)
            4'd2:                          month_len = 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:       month_len = 6'd30;
            default:                       month_len = 6'd31;
        endcase
    end

    always_comb
    begin
        tod_sum   = {1'b0, tod_reg} + {1'b0, TICK_UNITS};
        day_wrap  = tod_sum >= {1'b0, DAY_UNITS};
        day_inc   = {1'b0, day_reg} + 6'd1;
        month_inc = {1'b0, month_reg} + 5'd1;

        tod_next   = tod_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;

        if (advance)
        begin
            unique case (word.operation)
                OP_LOAD:
                begin
                    tod_next   = word.load_time;
                    day_next   = word.load_day;
                    month_next = word.load_month;
                    year_next  = word.load_year;
                end
                OP_TICK:
                begin
                    if (!day_wrap)
                    begin
                        tod_next = tod_sum[TIME_W-1:0];
                    end
                    else
                    begin
                        tod_next = '0;
                        if (day_inc > month_len)
                        begin
                            day_next = 5'd1;
                            if (month_inc > MONTHS)
                            begin
                                month_next = 4'd1;
                                year_next  = year_reg + 8'd1;
                            end
                            else
                            begin
                                month_next = month_inc[3:0];
                            end
                        end
                        else
                        begin
                            day_next = day_inc[4:0];
                        end
                    end
                end
                default:
                begin
                    tod_next = tod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tod_reg   <= '0;
            day_reg   <= DAY_RST;
            month_reg <= MONTH_RST;
            year_reg  <= YEAR_RST;
        end
        else
        begin
            tod_reg   <= tod_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign state.day   = day_reg;
    assign state.month = month_reg;
    assign state.year  = year_reg;
    assign state.tod   = tod_reg;

    a_tick_in_day: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && word.operation == OP_TICK) |=> (tod_reg < DAY_UNITS))
        else $error("time of day left the day after a tick");

    a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && word.operation == OP_TICK && tod_reg >= DAY_UNITS - TICK_UNITS)
        |=> (tod_reg == '0))
        else $error("day rollover did not clear the time of day");

    a_load_time: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && word.operation == OP_LOAD) |=> (tod_reg == $past(word.load_time)))
        else $error("load did not take the given time of day");

endmodule

[rtl/stcbt_slots.sv]
// Burst slot bank: enable mask, period registers, countdowns and fire mask.
// Depends on stcbt_pkg.
module stcbt_slots
#(
    parameter int BURST_SLOTS = stcbt_pkg::SLOT_MAX
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  stcbt_pkg::op_t                  operation,
    input  stcbt_pkg::cfg_wr_t              cfg,
    output logic [stcbt_pkg::SLOT_MAX-1:0]  fire
);
    import stcbt_pkg::*;

    logic [SLOT_MAX-1:0] enable_reg;
    logic [SLOT_MAX-1:0] fire_reg, fire_next;
    logic                tick;

    assign tick = advance && (operation == OP_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (cfg.en && cfg.idx == CFG_ENABLE)
        begin
            enable_reg <= cfg.data[SLOT_MAX-1:0];
        end
    end

    genvar i;
    generate
        for (i = 0; i < SLOT_MAX; i++)
        begin : g_slot
            if (i < BURST_SLOTS)
            begin : g_live
                logic [PERIOD_W-1:0] period_reg;
                logic [PERIOD_W-1:0] count_reg, count_next;
                logic                fires;

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        period_reg <= PERIOD_RST;
                    end
                    else if (cfg.en && cfg.idx == period_index(i))
                    begin
                        period_reg <= cfg.data;
                    end
                end

                // Fire and reload once a second or less is left; idle slots sit at the period
                always_comb
                begin
                    fires      = 1'b0;
                    count_next = count_reg;
                    if (tick)
                    begin
                        if (!enable_reg[i])
                        begin
                            count_next = period_reg;
                        end
                        else if (count_reg <= TICK_MS)
                        begin
                            fires      = 1'b1;
                            count_next = period_reg;
                        end
                        else
                        begin
                            count_next = count_reg - TICK_MS;
                        end
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        count_reg <= PERIOD_RST;
                    end
                    else
                    begin
                        count_reg <= count_next;
                    end
                end

                assign fire_next[i] = fires;
            end
            else
            begin : g_absent
                assign fire_next[i] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_reg <= '0;
        end
        else if (advance)
        begin
            fire_reg <= fire_next;
        end
    end

    assign fire = fire_reg;

    a_fire_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> ((fire_reg & ~$past(enable_reg)) == '0))
        else $error("disabled burst slot fired");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && operation == OP_LOAD) |=> (fire_reg == '0))
        else $error("burst fired on a load word");

endmodule

[bench/testbench.sv]
// Self-checking bench for second_tick_calendar_and_burst_timer: random and directed
// tick and load words checked against a bench-side calendar and burst slot predictor.
// Depends on stcbt_pkg and the RTL of the block.
module testbench;
    import stcbt_pkg::*;

    logic clk;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_idx_t   cfg_index = CFG_ENABLE;
    logic [PERIOD_W-1:0] cfg_data = '0;

    second_tick_calendar_and_burst_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copy of the calendar, slot countdowns and registers
    logic [4:0]          cal_day   = DAY_RST;
    logic [3:0]          cal_month = MONTH_RST;
    logic [7:0]          cal_year  = YEAR_RST;
    logic [TIME_W-1:0]   cal_time  = '0;
    logic [PERIOD_W-1:0] slot_left   [SLOT_MAX] = '{PERIOD_RST, PERIOD_RST, PERIOD_RST};
    logic [PERIOD_W-1:0] slot_period [SLOT_MAX] = '{PERIOD_RST, PERIOD_RST, PERIOD_RST};
    logic [SLOT_MAX-1:0] slot_enable = '0;

    in_word_t  input_backlog[$];
    out_word_t calendar_due[$];

    int unsigned mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    logic        drv_valid;
    in_word_t    drv_word;
    out_word_t   oldest;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [5:0] days_in(input logic [3:0] m);
        case (m)
            4'd2:                      return 6'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 6'd30;
            default:                   return 6'd31;
        endcase
    endfunction

    // Apply one word to the bench calendar and return the word the block should send
    function automatic out_word_t advance_calendar(input in_word_t w);
        out_word_t           r;
        logic [TIME_W:0]     sum;
        logic [5:0]          nd;
        logic [4:0]          nm;
        logic [SLOT_MAX-1:0] fire;
        int                  i;
        fire = '0;
        if (w.operation == OP_LOAD)
        begin
            cal_day   = w.load_day;
            cal_month = w.load_month;
            cal_year  = w.load_year;
            cal_time  = w.load_time;
        end
        else
        begin
            // carry bit kept so that a sum past 2^32 still rolls the day
            sum = {1'b0, cal_time} + {1'b0, TICK_UNITS};
            if (sum >= {1'b0, DAY_UNITS})
            begin
                cal_time = '0;
                nd = {1'b0, cal_day} + 6'd1;
                if (nd > days_in(cal_month))
                begin
                    nm = {1'b0, cal_month} + 5'd1;
                    nd = 6'd1;
                    if (nm > 5'd12)
                    begin
                        nm = 5'd1;
                        cal_year = cal_year + 8'd1;
                    end
                    cal_month = nm[3:0];
                end
                cal_day = nd[4:0];
            end
            else
                cal_time = sum[TIME_W-1:0];
            for (i = 0; i < SLOT_MAX; i++)
            begin
                if (!slot_enable[i])
                    slot_left[i] = slot_period[i];
                else if (slot_left[i] <= TICK_MS)
                begin
                    fire[i] = 1'b1;
                    slot_left[i] = slot_period[i];
                end
                else
                    slot_left[i] = slot_left[i] - TICK_MS;
            end
        end
        r.day_of_month    = cal_day;
        r.month_of_year   = cal_month;
        r.year_since_1900 = cal_year;
        r.time_of_day     = cal_time;
        r.burst_fire_mask = fire;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Sender: one word at a time from the backlog, with bursts of idle cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            drv_valid = in_valid;
            drv_word  = in_data;
            if (in_valid && in_ready)
            begin
                calendar_due.push_back(advance_calendar(in_data));
                drv_valid = 1'b0;
            end
            if (!drv_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(0, 11);
                else if (input_backlog.size() != 0)
                begin
                    drv_word  = input_backlog.pop_front();
                    drv_valid = 1'b1;
                end
            end
            in_valid <= drv_valid;
            in_data  <= drv_word;
        end
    end

    // Receiver: check each word taken against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (calendar_due.size() == 0)
                    flag_mismatch("word with nothing due", out_data.time_of_day, 0);
                else
                begin
                    oldest = calendar_due.pop_front();
                    if (out_data.day_of_month !== oldest.day_of_month)
                        flag_mismatch("day_of_month", out_data.day_of_month,
                                      oldest.day_of_month);
                    if (out_data.month_of_year !== oldest.month_of_year)
                        flag_mismatch("month_of_year", out_data.month_of_year,
                                      oldest.month_of_year);
                    if (out_data.year_since_1900 !== oldest.year_since_1900)
                        flag_mismatch("year_since_1900", out_data.year_since_1900,
                                      oldest.year_since_1900);
                    if (out_data.time_of_day !== oldest.time_of_day)
                        flag_mismatch("time_of_day", out_data.time_of_day,
                                      oldest.time_of_day);
                    if (out_data.burst_fire_mask !== oldest.burst_fire_mask)
                        flag_mismatch("burst_fire_mask", out_data.burst_fire_mask,
                                      oldest.burst_fire_mask);
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_stall = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic queue_load(input logic [4:0] d, input logic [3:0] m,
                              input logic [7:0] y, input logic [TIME_W-1:0] t);
        in_word_t w;
        w.operation  = OP_LOAD;
        w.load_day   = d;
        w.load_month = m;
        w.load_year  = y;
        w.load_time  = t;
        input_backlog.push_back(w);
    endtask

    // Load fields of a tick carry junk; the block must ignore them
    task automatic queue_ticks(input int n);
        in_word_t w;
        repeat (n)
        begin
            w.operation  = OP_TICK;
            w.load_day   = 5'($urandom);
            w.load_month = 4'($urandom);
            w.load_year  = 8'($urandom);
            w.load_time  = $urandom;
            input_backlog.push_back(w);
        end
    endtask

    task automatic set_register(input cfg_idx_t idx, input logic [PERIOD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ENABLE:  slot_enable    = val[SLOT_MAX-1:0];
            CFG_PERIOD0: slot_period[0] = val;
            CFG_PERIOD1: slot_period[1] = val;
            CFG_PERIOD2: slot_period[2] = val;
            default:     ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (input_backlog.size() != 0 || in_valid || calendar_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 22'd3600000;
            2:       return PERIOD_W'($urandom_range(0, 3600000));
            default: return PERIOD_W'($urandom_range(1000, 8000));
        endcase
    endfunction

    initial
    begin
        int          phase;
        int          sent;
        int          n;
        int unsigned pick;
        logic [3:0]  m;
        logic [2:0]  mask;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: no slot enabled, date 1/1/125
        queue_ticks(3);
        wait_drained();

        set_register(CFG_ENABLE, {19'($urandom), 3'b111});
        set_register(CFG_PERIOD0, 22'd0);
        set_register(CFG_PERIOD1, 22'd3600000);
        set_register(CFG_PERIOD2, 22'd2500);
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // year and month wrap together
        queue_load(5'd31, 4'd12, 8'd255, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        // last unit of the day, end of February
        queue_load(5'd28, 4'd2, 8'd100, DAY_UNITS - 1);
        queue_ticks(1);
        // sum carries past 2^32
        queue_load(5'd30, 4'd4, 8'd7, 32'hFFFF_FFFF);
        queue_ticks(1);
        // day zero and month zero
        queue_load(5'd0, 4'd0, 8'd0, DAY_UNITS - 5);
        queue_ticks(1);
        // months past twelve roll into January of the next year
        queue_load(5'd31, 4'd13, 8'd254, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        queue_load(5'd31, 4'd15, 8'd255, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        // day beyond the month length
        queue_load(5'd31, 4'd4, 8'd50, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        queue_load(5'd31, 4'd0, 8'd1, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        queue_load(5'd29, 4'd2, 8'd3, DAY_UNITS - TICK_UNITS);
        queue_ticks(1);
        queue_load(5'd15, 4'd6, 8'd200, '0);
        queue_ticks(3);
        wait_drained();

        for (phase = 1; phase <= 6; phase++)
        begin
            mask = 3'($urandom);
            if (phase == 1)
                mask = 3'b111;
            else if (phase == 2)
                mask = 3'b000;
            set_register(CFG_ENABLE, {19'($urandom), mask});
            set_register(CFG_PERIOD0, pick_period());
            set_register(CFG_PERIOD1, pick_period());
            set_register(CFG_PERIOD2, pick_period());
            if (phase == 6 || phase == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = $urandom_range(5, 35);
                recv_idle_pct = $urandom_range(5, 35);
            end

            sent = 0;
            while (sent < 66)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    // run across the end of a month
                    m = 4'($urandom_range(1, 12));
                    n = $urandom_range(1, 8);
                    queue_load(5'(days_in(m) - $urandom_range(0, 1)), m, 8'($urandom),
                               DAY_UNITS - TICK_UNITS * $urandom_range(1, 5)
                               - $urandom_range(0, 31999));
                end
                else if (pick < 80)
                begin
                    m = 4'($urandom_range(1, 12));
                    n = $urandom_range(1, 4);
                    queue_load(5'($urandom_range(1, days_in(m))), m, 8'($urandom),
                               $urandom_range(0, DAY_UNITS - 1));
                end
                else if (pick < 90)
                begin
                    n = $urandom_range(1, 6);
                    sent = sent - 1;
                end
                else
                begin
                    // unchecked ranges: any day, any month, any time
                    n = $urandom_range(0, 3);
                    queue_load(5'($urandom), 4'($urandom), 8'($urandom), $urandom);
                end
                queue_ticks(n);
                sent = sent + 1 + n;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
